// ===== rtl/core/fpac_pkg.sv =====
`timescale 1ns / 1ps
// fpac_pkg: shared types, fixed-point constants and fuzzy delta-gain tables
// for the fuzzy PID acceleration block. No dependencies.
package fpac_pkg;

  localparam int FRAC_BITS = 8;

  // thresholds, rounded to the Q format
  localparam int TH_0P1  = ((1 << FRAC_BITS) + 5) / 10;
  localparam int TH_0P15 = ((15 << FRAC_BITS) + 50) / 100;
  localparam int TH_0P2  = ((2 << FRAC_BITS) + 5) / 10;
  localparam int TH_0P3  = ((3 << FRAC_BITS) + 5) / 10;
  localparam int TH_0P5  = ((5 << FRAC_BITS) + 5) / 10;
  localparam int TH_1    = 1 << FRAC_BITS;
  localparam int TH_2    = 2 << FRAC_BITS;
  localparam int TH_3P5  = ((35 << FRAC_BITS) + 5) / 10;
  localparam int TH_4P5  = ((45 << FRAC_BITS) + 5) / 10;

  localparam logic signed [17:0] W_OLD  = 18'sd22938;
  localparam logic signed [17:0] W_NEW  = 18'sd9830;
  localparam logic signed [17:0] W_LEAK = 18'sd31130;

  localparam logic [2:0] REG_P_GAIN = 3'd0;
  localparam logic [2:0] REG_I_GAIN = 3'd1;
  localparam logic [2:0] REG_D_GAIN = 3'd2;
  localparam logic [2:0] REG_FLOOR  = 3'd3;
  localparam logic [2:0] REG_CEIL   = 3'd4;

  typedef logic signed [39:0] acc_t;
  typedef logic signed [17:0] opnd_t;
  typedef int tab_t [49];

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_e;

  typedef struct packed {
    acc_op_e            op;
    logic               dbl;
    logic signed [15:0] bias;
  } mac_ctl_t;

  typedef struct packed {
    opnd_t kp;
    opnd_t ki;
    opnd_t kd;
  } gains_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6,
    ST_F7, ST_F8, ST_F9, ST_F10, ST_F11
  } state_e;

  // table entries in units of 1e-4, row = E band, column = EC band
  localparam tab_t RAW_P = '{
    24300,19400,17700,12500,6900,4000,60,
    19400,19400,13500,6900,2600,30,-6000,
    17700,13500,9090,6900,-50,-2600,-10900,
    12500,8000,2600,1000,-1000,-6900,-12500,
    10900,2600,-40,-2600,-6900,-9090,-17700,
    5960,-1000,-2600,-8000,-13500,-13600,-19400,
    -60,-5000,-8000,-16700,-17700,-19400,-24300};
  localparam tab_t RAW_I = '{
    -24300,-19400,-17700,-12500,-6900,-4000,-60,
    -24300,-14800,-13500,-6900,-2600,-30,4000,
    -19400,-9090,-8000,-2600,1000,2600,6900,
    -17700,-8000,-1000,30,2600,9090,13500,
    -8000,-2600,50,6900,8000,13500,19400,
    -5000,-1000,2600,6930,13500,14800,24300,
    60,4000,6900,12500,17700,19400,24300};
  localparam tab_t RAW_D = '{
    10000,-3710,-14800,-24300,-19400,-4440,9700,
    6000,-3710,-14800,-13500,-13500,-3810,4000,
    4000,-3710,-13500,-9090,-6900,-6900,-120,
    -120,-6900,-6900,-6900,-5000,-6000,-119,
    5620,2180,0,0,0,2180,5620,
    9720,715,2620,6930,6900,8000,9720,
    24300,17700,16700,12500,10900,12000,24300};

  // delta gains in Q3.12, rounded half away from zero
  function automatic tab_t mk_delta_p();
    tab_t r;
    int   n;
    for (int k = 0; k < 49; k++) begin
      n = RAW_P[k] * 4096;
      r[k] = (n >= 0) ? (n + 50000) / 100000 : -((50000 - n) / 100000);
    end
    return r;
  endfunction

  function automatic tab_t mk_delta_i();
    tab_t r;
    int   n;
    for (int k = 0; k < 49; k++) begin
      n = RAW_I[k] * 4096;
      r[k] = (n >= 0) ? (n + 250000) / 500000 : -((250000 - n) / 500000);
    end
    return r;
  endfunction

  function automatic tab_t mk_delta_d();
    tab_t r;
    int   n;
    for (int k = 0; k < 49; k++) begin
      n = RAW_D[k] * 4096;
      r[k] = (n >= 0) ? (n + 100000) / 200000 : -((100000 - n) / 200000);
    end
    return r;
  endfunction

  localparam tab_t DELTA_P = mk_delta_p();
  localparam tab_t DELTA_I = mk_delta_i();
  localparam tab_t DELTA_D = mk_delta_d();

  function automatic logic signed [15:0] sat16(input acc_t x);
    logic signed [15:0] r;
    if (x > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/fuzzy_pid_accel_command.sv =====
`timescale 1ns / 1ps
// fuzzy_pid_accel_command: top level, APB registers, filter state and sequencer.
// Depends on fpac_pkg, fpac_mac, fpac_gain.
//
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o   | target_speed_i, measured_speed_i
// out     | output    | out_valid_o/out_stall_i | accel_command_o
// cfg     | input     | psel/penable/pready     | paddr, pwdata, prdata
//
// A word steps through states ST_F0 to ST_F11 from acceptance to a registered
// result, and a new word is taken only once that result is out; all products go
// through the single shared multiplier, one per cycle.
// in_stall_o is high while a word is in work; a stalled result holds
// only the final step. Reset clears state to zero and registers to defaults.
module fuzzy_pid_accel_command (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] target_speed_i,
  input  logic signed [15:0] measured_speed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] accel_command_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import fpac_pkg::*;

  state_e state_q, state_d;

  logic signed [15:0] kp_base_q, ki_base_q, kd_base_q, floor_q, ceil_q;
  logic signed [15:0] fe_q, fe_d, diff_q, diff_d, integ_q, integ_d;
  logic signed [15:0] last_q, last_d, out_q, out_d;
  logic signed [15:0] hist_q [4];
  logic signed [16:0] raw_q, pred;
  logic signed [15:0] e_clamp, inc, clamped;
  acc_t               lim_q, lim_d, rnd, step, acc;
  logic               out_valid_q, out_valid_d;
  logic               accept, done, gain_en, cfg_wr;
  opnd_t              op_a, op_b;
  mac_ctl_t           mac_ctl;
  gains_t             gains;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign accept = in_valid_i & (state_q == ST_IDLE);
  assign done   = (state_q == ST_F11) & (~out_valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_base_q <= '0;
      ki_base_q <= '0;
      kd_base_q <= '0;
      floor_q   <= 16'(-TH_4P5);
      ceil_q    <= 16'(TH_2);
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_P_GAIN: kp_base_q <= pwdata[15:0];
        REG_I_GAIN: ki_base_q <= pwdata[15:0];
        REG_D_GAIN: kd_base_q <= pwdata[15:0];
        REG_FLOOR:  floor_q   <= pwdata[15:0];
        REG_CEIL:   ceil_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_P_GAIN: prdata = 32'(kp_base_q);
      REG_I_GAIN: prdata = 32'(ki_base_q);
      REG_D_GAIN: prdata = 32'(kd_base_q);
      REG_FLOOR:  prdata = 32'(floor_q);
      REG_CEIL:   prdata = 32'(ceil_q);
      default:    prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_F0;
      ST_F0:   state_d = ST_F1;
      ST_F1:   state_d = ST_F2;
      ST_F2:   state_d = ST_F3;
      ST_F3:   state_d = ST_F4;
      ST_F4:   state_d = ST_F5;
      ST_F5:   state_d = ST_F6;
      ST_F6:   state_d = ST_F7;
      ST_F7:   state_d = ST_F8;
      ST_F8:   state_d = ST_F9;
      ST_F9:   state_d = ST_F10;
      ST_F10:  state_d = ST_F11;
      ST_F11:  if (done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign pred = 17'(fe_q) + 17'(diff_q >>> 2);

  // sequencer outputs
  always_comb begin
    op_a         = '0;
    op_b         = '0;
    mac_ctl.op   = ACC_HOLD;
    mac_ctl.dbl  = 1'b0;
    mac_ctl.bias = '0;
    gain_en      = 1'b0;
    unique case (state_q)
      ST_F0: begin
        op_a = W_OLD;
        op_b = opnd_t'(pred);
      end
      ST_F1: begin
        op_a = W_NEW;
        op_b = opnd_t'(raw_q);
        mac_ctl.op = ACC_LOAD;
      end
      ST_F2: begin
        mac_ctl.op   = ACC_ADD;
        mac_ctl.bias = 16'sd16384;
      end
      ST_F3: begin
        op_a = W_LEAK;
        op_b = opnd_t'(integ_q);
      end
      ST_F4: begin
        mac_ctl.op   = ACC_LOAD;
        mac_ctl.bias = 16'sd16384;
      end
      ST_F5: gain_en = 1'b1;
      ST_F6: begin
        op_a = gains.kp;
        op_b = opnd_t'(e_clamp);
      end
      ST_F7: begin
        op_a = gains.ki;
        op_b = opnd_t'(integ_q);
        mac_ctl.op = ACC_LOAD;
      end
      ST_F8: begin
        op_a = gains.kd;
        op_b = opnd_t'(diff_q);
        mac_ctl.op = ACC_ADD;
      end
      ST_F9: begin
        mac_ctl.op   = ACC_ADD;
        mac_ctl.dbl  = 1'b1;
        mac_ctl.bias = 16'sd2048;
      end
      default: ;
    endcase
  end

  fpac_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .ctl_i  (mac_ctl),
    .acc_o  (acc)
  );

  fpac_gain u_gain (
    .clk_i    (clk_i),
    .en_i     (gain_en),
    .err_i    (fe_q),
    .diff_i   (diff_q),
    .base_p_i (kp_base_q),
    .base_i_i (ki_base_q),
    .base_d_i (kd_base_q),
    .gains_o  (gains)
  );

  // datapath next values
  always_comb begin
    if (int'(fe_q) > TH_3P5) e_clamp = 16'(TH_3P5);
    else if (int'(fe_q) < -TH_4P5) e_clamp = 16'(-TH_4P5);
    else e_clamp = fe_q;

    if (int'(fe_q) > TH_0P15) inc = 16'(TH_0P15);
    else if (int'(fe_q) < -TH_0P15) inc = 16'(-TH_0P15);
    else inc = fe_q;

    fe_d    = (state_q == ST_F3) ? sat16(acc >>> 15) : fe_q;
    diff_d  = (state_q == ST_F4) ?
              sat16(acc_t'(hist_q[3]) + acc_t'(hist_q[2]) - acc_t'(hist_q[1])
                    - acc_t'(hist_q[0])) : diff_q;
    integ_d = (state_q == ST_F5) ? sat16((acc >>> 15) + acc_t'(inc)) : integ_q;

    rnd  = acc >>> 12;
    step = rnd - acc_t'(last_q);
    if (step > acc_t'(TH_0P1)) lim_d = acc_t'(last_q) + acc_t'(TH_0P1);
    else if (step < -acc_t'(TH_1)) lim_d = acc_t'(last_q) - acc_t'(TH_1);
    else lim_d = rnd;

    if (lim_q > acc_t'(ceil_q)) clamped = ceil_q;
    else if (lim_q < acc_t'(floor_q)) clamped = floor_q;
    else clamped = lim_q[15:0];

    last_d      = done ? clamped : last_q;
    out_d       = done ? clamped : out_q;
    out_valid_d = done | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      fe_q        <= '0;
      diff_q      <= '0;
      integ_q     <= '0;
      last_q      <= '0;
      for (int k = 0; k < 4; k++) hist_q[k] <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      fe_q        <= fe_d;
      diff_q      <= diff_d;
      integ_q     <= integ_d;
      last_q      <= last_d;
      if (state_q == ST_F3) begin
        hist_q[0] <= hist_q[1];
        hist_q[1] <= hist_q[2];
        hist_q[2] <= hist_q[3];
        hist_q[3] <= fe_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) raw_q <= 17'(target_speed_i) - 17'(measured_speed_i);
    if (state_q == ST_F10) lim_q <= lim_d;
    out_q <= out_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign accel_command_o = out_q;

endmodule

// ===== rtl/core/fpac_mac.sv =====
`timescale 1ns / 1ps
// fpac_mac: shared 18x18 signed multiplier with registered product and
// 40-bit accumulator. Depends on fpac_pkg.
module fpac_mac (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fpac_pkg::opnd_t  op_a_i,
  input  fpac_pkg::opnd_t  op_b_i,
  input  fpac_pkg::mac_ctl_t ctl_i,
  output fpac_pkg::acc_t   acc_o
);
  import fpac_pkg::*;

  logic signed [35:0] prod_q;
  acc_t               acc_q, acc_d, addend;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  always_comb begin
    addend = ctl_i.dbl ? (acc_t'(prod_q) <<< 1) : acc_t'(prod_q);
    addend = addend + acc_t'(ctl_i.bias);
    acc_d  = acc_q;
    unique case (ctl_i.op)
      ACC_LOAD: acc_d = addend;
      ACC_ADD:  acc_d = acc_q + addend;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/core/fpac_gain.sv =====
`timescale 1ns / 1ps
// fpac_gain: seven-band quantizers on error and difference, fuzzy table
// lookup and registered gain sums. Depends on fpac_pkg.
module fpac_gain (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] err_i,
  input  logic signed [15:0] diff_i,
  input  logic signed [15:0] base_p_i,
  input  logic signed [15:0] base_i_i,
  input  logic signed [15:0] base_d_i,
  output fpac_pkg::gains_t   gains_o
);
  import fpac_pkg::*;

  logic [2:0] ie, iec;
  logic [5:0] idx;
  gains_t     gains_q, gains_d;

  always_comb begin
    if (int'(err_i) <= -TH_1) ie = 3'd0;
    else if (int'(err_i) <= -TH_0P5) ie = 3'd1;
    else if (int'(err_i) <= -TH_0P2) ie = 3'd2;
    else if (int'(err_i) <= TH_0P2) ie = 3'd3;
    else if (int'(err_i) <= TH_0P5) ie = 3'd4;
    else if (int'(err_i) <= TH_1) ie = 3'd5;
    else ie = 3'd6;

    if (int'(diff_i) <= -TH_0P3) iec = 3'd0;
    else if (int'(diff_i) <= -TH_0P2) iec = 3'd1;
    else if (int'(diff_i) <= -TH_0P1) iec = 3'd2;
    else if (int'(diff_i) <= TH_0P1) iec = 3'd3;
    else if (int'(diff_i) <= TH_0P2) iec = 3'd4;
    else if (int'(diff_i) <= TH_0P3) iec = 3'd5;
    else iec = 3'd6;

    idx = 6'(ie * 7) + 6'(iec);
    gains_d.kp = opnd_t'(base_p_i) + opnd_t'(DELTA_P[idx]);
    gains_d.ki = opnd_t'(base_i_i) + opnd_t'(DELTA_I[idx]);
    gains_d.kd = opnd_t'(base_d_i) + opnd_t'(DELTA_D[idx]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gains_q <= gains_d;
    end
  end

  assign gains_o = gains_q;

endmodule

// ===== rtl/core/fpac_checker.sv =====
`timescale 1ns / 1ps
// fpac_checker: port-level checks for fuzzy_pid_accel_command, bound to the
// top level below. Depends on nothing else.
module fpac_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] accel_command_o,
  input logic               pready
);

  // an accepted word keeps the block busy afterwards
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o ##1 in_stall_o)
    else $error("block not busy after accepting a word");

  // the block frees up only with a result on the output
  a_result_at_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("block released without a result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(accel_command_o)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind fuzzy_pid_accel_command fpac_checker u_fpac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .accel_command_o (accel_command_o),
  .pready          (pready)
);

// ===== tb/fuzzy_pid_accel_command_test.sv =====
`timescale 1ns / 1ps
// fuzzy_pid_accel_command_test: self-checking bench for the fuzzy PID accel block.
// Depends on fpac_pkg and fuzzy_pid_accel_command; holds its own bit-exact predictor.
module fuzzy_pid_accel_command_test;
  import fpac_pkg::*;

  class accel_scoreboard;
    int tp[49] = '{
      24300,19400,17700,12500,6900,4000,60,
      19400,19400,13500,6900,2600,30,-6000,
      17700,13500,9090,6900,-50,-2600,-10900,
      12500,8000,2600,1000,-1000,-6900,-12500,
      10900,2600,-40,-2600,-6900,-9090,-17700,
      5960,-1000,-2600,-8000,-13500,-13600,-19400,
      -60,-5000,-8000,-16700,-17700,-19400,-24300};
    int ti[49] = '{
      -24300,-19400,-17700,-12500,-6900,-4000,-60,
      -24300,-14800,-13500,-6900,-2600,-30,4000,
      -19400,-9090,-8000,-2600,1000,2600,6900,
      -17700,-8000,-1000,30,2600,9090,13500,
      -8000,-2600,50,6900,8000,13500,19400,
      -5000,-1000,2600,6930,13500,14800,24300,
      60,4000,6900,12500,17700,19400,24300};
    int td[49] = '{
      10000,-3710,-14800,-24300,-19400,-4440,9700,
      6000,-3710,-14800,-13500,-13500,-3810,4000,
      4000,-3710,-13500,-9090,-6900,-6900,-120,
      -120,-6900,-6900,-6900,-5000,-6000,-119,
      5620,2180,0,0,0,2180,5620,
      9720,715,2620,6930,6900,8000,9720,
      24300,17700,16700,12500,10900,12000,24300};
    longint kp_base, ki_base, kd_base, lo_lim, hi_lim;
    longint ferr, hist[4], ediff, integ, last;
    logic signed [15:0] pending[$];
    int errors, words_in, words_out;

    function new();
      kp_base = 0; ki_base = 0; kd_base = 0; lo_lim = -TH_4P5; hi_lim = TH_2;
      ferr = 0; hist = '{0, 0, 0, 0}; ediff = 0; integ = 0; last = 0;
      errors = 0; words_in = 0; words_out = 0;
    endfunction

    function longint clip16(longint x);
      return (x > 32767) ? 32767 : (x < -32768) ? -32768 : x;
    endfunction

    function longint fuzz_delta(int entry, longint u);
      longint n, d;
      n = longint'(entry) * 4096;
      d = 10000 * u;
      return (n >= 0) ? (n + d / 2) / d : -((d / 2 - n) / d);
    endfunction

    function int band(longint v, longint a, longint b, longint c);
      if (v <= -a) return 0;
      if (v <= -b) return 1;
      if (v <= -c) return 2;
      if (v <= c) return 3;
      if (v <= b) return 4;
      if (v <= a) return 5;
      return 6;
    endfunction

    function void note_speeds(logic signed [15:0] tgt, logic signed [15:0] meas);
      longint raw, pred, inc, e, kp, ki, kd, acc;
      int k;
      raw = longint'(tgt) - longint'(meas);
      pred = ferr + (ediff >>> 2);
      ferr = clip16((22938 * pred + 9830 * raw + 16384) >>> 15);
      hist[0] = hist[1]; hist[1] = hist[2]; hist[2] = hist[3]; hist[3] = ferr;
      ediff = clip16(hist[3] + hist[2] - hist[1] - hist[0]);
      inc = (ferr > TH_0P15) ? TH_0P15 : (ferr < -TH_0P15) ? -TH_0P15 : ferr;
      integ = clip16(((31130 * integ + 16384) >>> 15) + inc);
      e = (ferr > TH_3P5) ? TH_3P5 : (ferr < -TH_4P5) ? -TH_4P5 : ferr;
      k = band(ferr, TH_1, TH_0P5, TH_0P2) * 7 + band(ediff, TH_0P3, TH_0P2, TH_0P1);
      kp = kp_base + fuzz_delta(tp[k], 10);
      ki = ki_base + fuzz_delta(ti[k], 50);
      kd = kd_base + fuzz_delta(td[k], 20);
      acc = (kp * e + ki * integ + 2 * kd * ediff + 2048) >>> 12;
      if (acc - last > TH_0P1) acc = last + TH_0P1;
      else if (acc - last < -TH_1) acc = last - TH_1;
      if (acc > hi_lim) acc = hi_lim;
      else if (acc < lo_lim) acc = lo_lim;
      last = clip16(acc);
      pending.push_back(last[15:0]);
      words_in++;
    endfunction

    function void check_command(logic signed [15:0] got);
      logic signed [15:0] want;
      words_out++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected accel_command %0d", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("accel_command mismatch: expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_stall_o, out_valid_o, out_stall_i = 0;
  logic signed [15:0] target_speed_i = 0, measured_speed_i = 0, accel_command_o;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  int idle_pct = 0, stall_pct = 0;
  int cycles = 0;
  accel_scoreboard sb = new();

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  fuzzy_pid_accel_command i_dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout");
      $display("fuzzy_pid_accel_command_test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_speeds(target_speed_i, measured_speed_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_command(accel_command_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic write_reg(logic [2:0] idx, logic signed [15:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= {{16{val[15]}}, val};
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_P_GAIN: sb.kp_base = val;
      REG_I_GAIN: sb.ki_base = val;
      REG_D_GAIN: sb.kd_base = val;
      REG_FLOOR:  sb.lo_lim = val;
      REG_CEIL:   sb.hi_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_gains(int p, int i, int d, int lo, int hi);
    write_reg(REG_P_GAIN, 16'(p));
    write_reg(REG_I_GAIN, 16'(i));
    write_reg(REG_D_GAIN, 16'(d));
    write_reg(REG_FLOOR, 16'(lo));
    write_reg(REG_CEIL, 16'(hi));
  endtask

  task automatic send_word(logic signed [15:0] tgt, logic signed [15:0] meas);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; target_speed_i <= tgt; measured_speed_i <= meas;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_words(int n);
    logic signed [15:0] t;
    int d;
    repeat (n) begin
      t = 16'($urandom);
      if ($urandom_range(99) < 80) begin
        d = $urandom_range(1200) - 600;
        send_word(t, 16'(int'(t) - d));
      end else send_word(16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed words at reset defaults: extremes, band edges, sign flips
    send_word(16'sh7fff, 16'sh8000);
    send_word(16'sh8000, 16'sh7fff);
    send_word(0, 0);
    send_word(16'sh7fff, 16'sh7fff);
    send_word(16'sh8000, 16'sh8000);
    send_word(256, 0);
    send_word(128, 0);
    send_word(51, 0);
    send_word(-51, 0);
    send_word(-128, 0);
    send_word(-256, 0);
    send_word(38, 0);
    send_word(-38, 0);
    send_word(0, 300);
    send_word(300, 0);
    send_word(1000, 0);
    send_word(-1000, 0);
    send_word(0, 0);
    send_word(16'sh5555, 16'shaaaa);
    send_word(16'shaaaa, 16'sh5555);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_gains(4096, 1024, 2048, -1152, 512);
        1: set_gains(32767, -32768, 32767, -32768, 32767);
        2: set_gains(-32768, 32767, -32768, 300, -300);
        default: set_gains($urandom, $urandom, $urandom, -int'($urandom_range(2000)),
                           $urandom_range(2000));
      endcase
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 71 : 22) : 0;
      stall_pct = (ph == 2) ? 71 : (ph == 3) ? 22 : 0;
      random_words(170);
      drain();
    end
    $display("drove %0d speed words over five gain settings, %0d commands checked",
             sb.words_in, sb.words_out);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("fuzzy_pid_accel_command_test passed");
    end else begin
      $display("%0d mismatches, %0d missing", sb.errors, sb.pending.size());
      $display("fuzzy_pid_accel_command_test failed");
    end
    $finish;
  end
endmodule
